>>> sv/jse_pkg.sv
// ============================================================================
// jse_pkg - shared types and constants of the JSON string escaper
// Byte classes, the step record passed from front to back, and helpers
// for UTF-8 lead and continuation checks and escaped byte generation.
// ============================================================================
package jse_pkg;

    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_ESC  = 2'd1,
        KIND_CTRL = 2'd2,
        KIND_REPL = 2'd3
    } jse_kind_t;

    // One input byte's worth of work: up to four tokens, each a buffered byte
    // with the way it is to be written out.
    typedef struct packed {
        logic      [3:0][7:0] bytes;
        jse_kind_t [3:0]      kinds;
        logic      [1:0]      last_tok;
        logic                 last;
    } jse_step_t;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_U     = 8'h75;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] HEX_ALPHA  = 8'h57;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] REPL_B0    = 8'hEF;
    localparam logic [7:0] REPL_B1    = 8'hBF;
    localparam logic [7:0] REPL_B2    = 8'hBD;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hBF;
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_SURR = 8'hED;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;
    localparam logic [7:0] E0_MIN     = 8'hA0;
    localparam logic [7:0] ED_MAX     = 8'h9F;
    localparam logic [7:0] F0_MIN     = 8'h90;
    localparam logic [7:0] F4_MAX     = 8'h8F;

    // Sequence length for a lead byte, zero for a byte that cannot lead.
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        if (b < CONT_LO)
            len = 3'd1;
        else if (b >= LEAD2_LO && b < LEAD3_LO)
            len = 3'd2;
        else if (b >= LEAD3_LO && b < LEAD4_LO)
            len = 3'd3;
        else if (b >= LEAD4_LO && b <= LEAD4_HI)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

    // Continuation check; the tighter limits apply to the second byte only.
    function automatic logic follow_ok(input logic [7:0] lead, input logic second,
                                       input logic [7:0] b);
        logic ok;
        ok = (b >= CONT_LO) && (b <= CONT_HI);
        if (second)
        begin
            if (lead == LEAD3_LO   && b < E0_MIN) ok = 1'b0;
            if (lead == LEAD3_SURR && b > ED_MAX) ok = 1'b0;
            if (lead == LEAD4_LO   && b < F0_MIN) ok = 1'b0;
            if (lead == LEAD4_HI   && b > F4_MAX) ok = 1'b0;
        end
        return ok;
    endfunction

    // Class of a byte scanned on its own as a lead.
    function automatic jse_kind_t classify(input logic [7:0] b);
        jse_kind_t k;
        if (b == CHAR_QUOTE || b == CHAR_BSL)
            k = KIND_ESC;
        else if (b < CTRL_LIMIT)
            k = KIND_CTRL;
        else if (b < CONT_LO)
            k = KIND_PASS;
        else
            k = KIND_REPL;
        return k;
    endfunction

    function automatic logic [2:0] kind_last_sub(input jse_kind_t k);
        logic [2:0] s;
        unique case (k)
            KIND_PASS: s = 3'd0;
            KIND_ESC:  s = 3'd1;
            KIND_CTRL: s = 3'd5;
            KIND_REPL: s = 3'd2;
            default:   s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        if (v < 4'd10)
            d = CHAR_ZERO + {4'd0, v};
        else
            d = HEX_ALPHA + {4'd0, v};
        return d;
    endfunction

    function automatic logic [7:0] out_char(input jse_kind_t k, input logic [2:0] sub,
                                            input logic [7:0] b);
        logic [7:0] c;
        unique case (k)
            KIND_PASS: c = b;
            KIND_ESC:  c = (sub == 3'd0) ? CHAR_BSL : b;
            KIND_CTRL:
            begin
                unique case (sub)
                    3'd0:    c = CHAR_BSL;
                    3'd1:    c = CHAR_U;
                    3'd2:    c = CHAR_ZERO;
                    3'd3:    c = CHAR_ZERO;
                    3'd4:    c = hex_digit(b[7:4]);
                    default: c = hex_digit(b[3:0]);
                endcase
            end
            KIND_REPL:
            begin
                unique case (sub)
                    3'd0:    c = REPL_B0;
                    3'd1:    c = REPL_B1;
                    default: c = REPL_B2;
                endcase
            end
            default: c = b;
        endcase
        return c;
    endfunction

endpackage

>>> sv/jse_front.sv
// ============================================================================
// jse_front - input side of the JSON string escaper
// Holds the bytes of an unfinished UTF-8 sequence and turns accepted bytes
// into step records of tokens for the output side.
// ============================================================================
module jse_front
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output jse_step_t  step
);

    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] pend_reg [3];

    logic       x_multi;
    jse_kind_t  x_kind;
    logic [2:0] lead_len;
    logic       follow;
    logic       seq_full;
    logic       emit;
    logic       load_x;
    logic       append;
    jse_kind_t  pend_kind;
    jse_kind_t  tail_kind;
    logic [1:0] last_tok;

    assign x_multi  = (seq_len(in_byte) >= 3'd2);
    assign x_kind   = classify(in_byte);
    assign lead_len = seq_len(pend_reg[0]);
    assign follow   = follow_ok(pend_reg[0], cnt_reg == 2'd1, in_byte);
    assign seq_full = (({1'b0, cnt_reg} + 3'd1) == lead_len);

    // Held bytes always form a valid prefix, so a failed or truncated
    // sequence only ever gives replacements for them; the new byte is
    // the only one that may start a fresh sequence.
    always_comb
    begin
        emit      = 1'b0;
        load_x    = 1'b0;
        append    = 1'b0;
        cnt_next  = 2'd0;
        pend_kind = KIND_REPL;
        tail_kind = x_kind;
        last_tok  = cnt_reg;
        if (cnt_reg == 2'd0)
        begin
            if (x_multi && !in_last)
            begin
                load_x   = 1'b1;
                cnt_next = 2'd1;
            end
            else
            begin
                emit = 1'b1;
            end
        end
        else if (follow)
        begin
            if (seq_full)
            begin
                emit      = 1'b1;
                pend_kind = KIND_PASS;
                tail_kind = KIND_PASS;
            end
            else if (in_last)
            begin
                emit      = 1'b1;
                tail_kind = KIND_REPL;
            end
            else
            begin
                append   = 1'b1;
                cnt_next = cnt_reg + 2'd1;
            end
        end
        else
        begin
            emit = 1'b1;
            if (x_multi && !in_last)
            begin
                load_x   = 1'b1;
                cnt_next = 2'd1;
                last_tok = cnt_reg - 2'd1;
            end
        end
    end

    always_comb
    begin
        step.bytes[0] = (cnt_reg == 2'd0) ? in_byte : pend_reg[0];
        step.bytes[1] = (cnt_reg == 2'd1) ? in_byte : pend_reg[1];
        step.bytes[2] = (cnt_reg == 2'd2) ? in_byte : pend_reg[2];
        step.bytes[3] = in_byte;
        for (int i = 0; i < 4; i++)
        begin
            step.kinds[i] = (cnt_reg == 2'(i)) ? tail_kind : pend_kind;
        end
        step.last_tok = last_tok;
        step.last     = in_last;
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (accept)
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (load_x && i == 0)
                    pend_reg[i] <= in_byte;
                else if (append && cnt_reg == 2'(i))
                    pend_reg[i] <= in_byte;
            end
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (cnt_reg == 2'd0))
        else $error("pending bytes left over after final byte");

endmodule

>>> sv/jse_queue.sv
// ============================================================================
// jse_queue - step queue between front and back
// Small register FIFO of step records; the head is visible without a pop.
// ============================================================================
module jse_queue
    import jse_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  jse_step_t wr_data,
    input  logic      pop,
    output logic      full,
    output logic      head_valid,
    output jse_step_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jse_step_t         mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("step queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("step queue popped while empty");

endmodule

>>> sv/jse_back.sv
// ============================================================================
// jse_back - output side of the JSON string escaper
// Walks the head step's tokens and, while a step is queued and the output
// is not stalled, writes one escaped byte per cycle into the output register.
// ============================================================================
module jse_back
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  jse_step_t  head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_end
);

    logic [1:0] tok_reg, tok_next;
    logic [2:0] sub_reg, sub_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       run_last_reg;
    logic       end_reg;

    jse_kind_t  cur_kind;
    logic [7:0] cur_byte;
    logic       load;
    logic       tok_done;
    logic       step_done;

    assign cur_kind  = head.kinds[tok_reg];
    assign cur_byte  = head.bytes[tok_reg];
    assign load      = head_valid && (!valid_reg || out_ready);
    assign tok_done  = (sub_reg == kind_last_sub(cur_kind));
    assign step_done = tok_done && (tok_reg == head.last_tok);
    assign pop       = load && step_done;

    always_comb
    begin
        tok_next   = tok_reg;
        sub_next   = sub_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            if (step_done)
            begin
                tok_next = 2'd0;
                sub_next = 3'd0;
            end
            else if (tok_done)
            begin
                tok_next = tok_reg + 2'd1;
                sub_next = 3'd0;
            end
            else
            begin
                sub_next = sub_reg + 3'd1;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= 2'd0;
            sub_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg   <= tok_next;
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg     <= out_char(cur_kind, sub_reg, cur_byte);
            run_last_reg <= step_done;
            end_reg      <= step_done && head.last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign run_last   = run_last_reg;
    assign string_end = end_reg;

    a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (tok_reg == 2'd0 && sub_reg == 3'd0))
        else $error("token walk not at start with queue empty");

    a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (sub_reg <= kind_last_sub(cur_kind) && tok_reg <= head.last_tok))
        else $error("token walk beyond the head step");

endmodule

>>> sv/json_string_escaper_utf8_top.sv
// ============================================================================
// json_string_escaper_utf8_top - JSON string escaper with UTF-8 validation
// Escapes a byte stream for a JSON string and replaces bad UTF-8.
// ============================================================================
// Each input byte is taken while the step queue has room; while a step is
// queued and the output is not stalled, the output side writes exactly one
// escaped byte per cycle. A plain byte gives one output byte, a quote or
// backslash two, a control byte six, each replacement three, and a byte
// held as part of an unfinished UTF-8 sequence none (a completed sequence
// then emits all its bytes in one step). The output serializer is what sets
// the sustained rate; QUEUE_DEPTH steps of slack let the input keep flowing
// across short output stalls. No clearing pass is needed after reset.
module json_string_escaper_utf8_top
    import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_end
);

    logic      accept;
    logic      push;
    logic      pop;
    logic      full;
    logic      head_valid;
    jse_step_t step;
    jse_step_t head;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    jse_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .push    (push),
        .step    (step)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_data    (step),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule

>>> dv/json_string_escaper_utf8_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// json_string_escaper_utf8_top_tb - self-checking bench for the JSON escaper
// Feeds strings byte by byte over valid/ready, predicts the escaped output
// with a local UTF-8 scanner, and compares every output transfer in order.
// ============================================================================
module json_string_escaper_utf8_top_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_LIMIT = 20;
    localparam int RANDOM_ITEMS = 170;
    localparam int MAX_PER_BYTE = 15;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_BEAT,
        RX_LIGHT
    } rx_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       str_end;
    } esc_byte_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    json_string_escaper_utf8_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .string_end (string_end)
    );

    // Scanner state of the predictor
    logic [7:0] held_b [3];
    int         held_cnt;

    esc_byte_t  escaped_q[$];
    esc_byte_t  step_q[$];
    logic [7:0] str_q[$];

    int         err_count;
    int         bytes_sent;
    int         strings_sent;
    int         bytes_checked;
    int         burst_left;
    int         rx_hold;
    int         cycle_count = 0;
    rx_mode_t   rx_mode;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("json_string_escaper_utf8_top_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int utf8_len(input logic [7:0] lead);
        int len;
        if (lead < 8'h80)
            len = 1;
        else if (lead >= 8'hC2 && lead <= 8'hDF)
            len = 2;
        else if (lead >= 8'hE0 && lead <= 8'hEF)
            len = 3;
        else if (lead >= 8'hF0 && lead <= 8'hF4)
            len = 4;
        else
            len = 0;
        return len;
    endfunction

    function automatic logic cont_ok(input logic [7:0] lead, input int idx,
                                     input logic [7:0] b);
        logic ok;
        ok = (b >= 8'h80) && (b <= 8'hBF);
        if (idx == 1)
        begin
            if (lead == 8'hE0 && b < 8'hA0) ok = 1'b0;
            if (lead == 8'hED && b > 8'h9F) ok = 1'b0;
            if (lead == 8'hF0 && b < 8'h90) ok = 1'b0;
            if (lead == 8'hF4 && b > 8'h8F) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
            c = 8'h30 + {4'd0, nib};
        else
            c = 8'h61 + {4'd0, nib} - 8'd10;
        return c;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        esc_byte_t e;
        if (step_q.size() < MAX_PER_BYTE)
        begin
            e.data    = b;
            e.run_end = 1'b0;
            e.str_end = 1'b0;
            step_q.push_back(e);
        end
    endfunction

    function automatic void put_repl();
        put_byte(8'hEF);
        put_byte(8'hBF);
        put_byte(8'hBD);
    endfunction

    task automatic predict_escape(input logic [7:0] b, input logic last);
        logic [7:0] scan_b [4];
        logic [7:0] cur;
        esc_byte_t  e;
        int         cnt;
        int         pos;
        int         len;
        int         avail;
        int         lim;
        int         k;
        logic       ok;
        logic       held;
        cnt = held_cnt;
        for (k = 0; k < cnt; k++)
            scan_b[k] = held_b[k];
        scan_b[cnt] = b;
        cnt++;
        pos  = 0;
        held = 1'b0;
        step_q.delete();
        while (!held && pos < cnt)
        begin
            cur = scan_b[pos];
            if (cur < 8'h80)
            begin
                if (cur == 8'h22 || cur == 8'h5C)
                begin
                    put_byte(8'h5C);
                    put_byte(cur);
                end
                else if (cur < 8'h20)
                begin
                    put_byte(8'h5C);
                    put_byte(8'h75);
                    put_byte(8'h30);
                    put_byte(8'h30);
                    put_byte(hex_char(cur[7:4]));
                    put_byte(hex_char(cur[3:0]));
                end
                else
                    put_byte(cur);
                pos++;
            end
            else
            begin
                len = utf8_len(cur);
                if (len == 0)
                begin
                    put_repl();
                    pos++;
                end
                else
                begin
                    avail = cnt - pos;
                    lim   = (avail < len) ? avail : len;
                    ok    = 1'b1;
                    for (k = 1; k < lim; k++)
                        if (ok && !cont_ok(cur, k, scan_b[pos + k]))
                            ok = 1'b0;
                    if (!ok)
                    begin
                        // replace the lead alone, rescan what follows it
                        put_repl();
                        pos++;
                    end
                    else if (avail < len)
                    begin
                        if (last)
                        begin
                            put_repl();
                            pos++;
                        end
                        else
                            held = 1'b1;
                    end
                    else
                    begin
                        for (k = 0; k < len; k++)
                            put_byte(scan_b[pos + k]);
                        pos += len;
                    end
                end
            end
        end
        held_cnt = 0;
        for (k = pos; k < cnt; k++)
            if (held_cnt < 3)
            begin
                held_b[held_cnt] = scan_b[k];
                held_cnt++;
            end
        if (step_q.size() > 0)
        begin
            e         = step_q.pop_back();
            e.run_end = 1'b1;
            e.str_end = last;
            step_q.push_back(e);
        end
        for (k = 0; k < step_q.size(); k++)
            escaped_q.push_back(step_q[k]);
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        do @(posedge clk); while (!in_ready);
        predict_escape(b, last);
        bytes_sent++;
        // close the burst with a gap now and then
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_string();
        int k;
        for (k = 0; k < str_q.size(); k++)
            send_byte(str_q[k], k == str_q.size() - 1);
        strings_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (escaped_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_LIMIT) @(posedge clk);
    endtask

    function automatic void add_utf8(input logic [20:0] cp);
        if (cp < 21'h80)
            str_q.push_back(cp[7:0]);
        else if (cp < 21'h800)
        begin
            str_q.push_back({3'b110, cp[10:6]});
            str_q.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            str_q.push_back({4'b1110, cp[15:12]});
            str_q.push_back({2'b10, cp[11:6]});
            str_q.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            str_q.push_back({5'b11110, cp[20:18]});
            str_q.push_back({2'b10, cp[17:12]});
            str_q.push_back({2'b10, cp[11:6]});
            str_q.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function automatic logic [20:0] pick_code_point(input int nbytes);
        logic [20:0] cp;
        logic        corner;
        corner = ($urandom_range(0, 5) == 0);
        case (nbytes)
            2:
            begin
                cp = 21'($urandom_range(21'h80, 21'h7FF));
                if (corner) cp = $urandom_range(0, 1) ? 21'h80 : 21'h7FF;
            end
            3:
            begin
                cp = 21'($urandom_range(21'h800, 21'hFFFF));
                // move surrogates out of the way
                if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
                if (corner)
                    case ($urandom_range(0, 3))
                        0:       cp = 21'h800;
                        1:       cp = 21'hD7FF;
                        2:       cp = 21'hE000;
                        default: cp = 21'hFFFF;
                    endcase
            end
            default:
            begin
                cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
                if (corner) cp = $urandom_range(0, 1) ? 21'h10000 : 21'h10FFFF;
            end
        endcase
        return cp;
    endfunction

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------
    initial
    begin
        esc_byte_t  want;
        logic       fire;
        logic [7:0] got_byte;
        logic       got_run;
        logic       got_end;
        logic       rdy;
        int         rx_cnt;
        out_ready <= 1'b0;
        rx_cnt = 0;
        forever
        begin
            @(posedge clk);
            fire     = rst_n && out_valid && out_ready;
            got_byte = out_byte;
            got_run  = run_last;
            got_end  = string_end;
            rx_cnt++;
            if (rx_cnt % 128 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            if (rx_hold > 0)
            begin
                rx_hold--;
                rdy = 1'b0;
            end
            else
                case (rx_mode)
                    RX_OPEN:  rdy = 1'b1;
                    RX_COIN:  rdy = 1'($urandom_range(0, 1));
                    RX_BEAT:  rdy = (rx_cnt % 5) < 3;
                    default:  rdy = ($urandom_range(0, 7) != 0);
                endcase
            out_ready <= rdy;
            if (fire)
            begin
                // let the sender record what it handed over at this edge
                #1;
                if (escaped_q.size() == 0)
                begin
                    $error("unexpected transfer: out_byte %h", got_byte);
                    err_count++;
                end
                else
                begin
                    want = escaped_q.pop_front();
                    bytes_checked++;
                    if (got_byte !== want.data)
                    begin
                        $error("out_byte expected %h actual %h", want.data, got_byte);
                        err_count++;
                    end
                    if (got_run !== want.run_end)
                    begin
                        $error("run_last expected %b actual %b", want.run_end, got_run);
                        err_count++;
                    end
                    if (got_end !== want.str_end)
                    begin
                        $error("string_end expected %b actual %b", want.str_end, got_end);
                        err_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_ascii_escapes();
        str_q = '{8'h00, 8'h1F, 8'h22, 8'h5C, 8'h20, 8'h7F};
        send_string();
        wait_drained();
    endtask

    task automatic test_bad_leads();
        str_q = '{8'h80, 8'hC1, 8'hF5, 8'hFF};
        send_string();
        wait_drained();
    endtask

    task automatic test_second_byte_limits();
        str_q = '{8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF0, 8'h8F, 8'hF4, 8'h90};
        send_string();
        wait_drained();
    endtask

    task automatic test_truncation();
        // three held bytes broken by a control byte: the widest expansion
        str_q = '{8'hF4, 8'h8F, 8'hBF, 8'h0A};
        send_string();
        // a valid pair, then a prefix cut short by the end of the string
        str_q = '{8'hDF, 8'hBF, 8'hE0, 8'hA0};
        send_string();
        wait_drained();
    endtask

    task automatic test_backpressure();
        int k;
        rx_hold = 400;
        str_q.delete();
        for (k = 0; k < 30; k++)
            str_q.push_back(8'($urandom_range(0, 8'h1F)));
        send_string();
        wait_drained();
    endtask

    task automatic test_random_text();
        int          n_items;
        int          len;
        int          k;
        int          kind;
        int          nb;
        int          cut;
        logic [20:0] cp;
        n_items = 0;
        while (n_items < RANDOM_ITEMS)
        begin
            str_q.delete();
            len = $urandom_range(1, 10);
            for (k = 0; k < len; k++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 25)
                    str_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                else if (kind < 33)
                    str_q.push_back($urandom_range(0, 1) ? 8'h22 : 8'h5C);
                else if (kind < 41)
                    str_q.push_back(8'($urandom_range(0, 8'h1F)));
                else if (kind < 82)
                begin
                    nb = (kind < 55) ? 2 : (kind < 70) ? 3 : 4;
                    add_utf8(pick_code_point(nb));
                end
                else if (kind < 88)
                    str_q.push_back(8'($urandom_range(0, 255)));
                else if (kind < 94)
                begin
                    // truncated sequence: drop one or more trailing bytes
                    nb = $urandom_range(2, 4);
                    add_utf8(pick_code_point(nb));
                    cut = $urandom_range(1, nb - 1);
                    repeat (cut) void'(str_q.pop_back());
                end
                else
                    case ($urandom_range(0, 4))
                        0:
                        begin
                            str_q.push_back(8'hE0);
                            str_q.push_back(8'($urandom_range(8'h80, 8'h9F)));
                        end
                        1:
                        begin
                            str_q.push_back(8'hED);
                            str_q.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                        end
                        2:
                        begin
                            str_q.push_back(8'hF0);
                            str_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
                        end
                        3:
                        begin
                            str_q.push_back(8'hF4);
                            str_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
                        end
                        default:
                        begin
                            str_q.push_back(8'($urandom_range(8'hC2, 8'hF4)));
                            str_q.push_back(8'($urandom_range(0, 1) ?
                                               $urandom_range(0, 8'h7F) :
                                               $urandom_range(8'hC0, 8'hFF)));
                        end
                    endcase
            end
            n_items += str_q.size();
            send_string();
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        in_byte       <= 8'h00;
        in_last       <= 1'b0;
        held_cnt      = 0;
        err_count     = 0;
        bytes_sent    = 0;
        strings_sent  = 0;
        bytes_checked = 0;
        burst_left    = 0;
        rx_hold       = 0;
        rx_mode       = RX_OPEN;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_ascii_escapes();
        test_bad_leads();
        test_second_byte_limits();
        test_truncation();
        test_backpressure();
        test_random_text();

        if (escaped_q.size() != 0)
        begin
            $error("%0d escaped bytes never arrived", escaped_q.size());
            err_count++;
        end
        $display("sent %0d bytes in %0d strings, checked %0d escaped bytes",
                 bytes_sent, strings_sent, bytes_checked);
        $display("covered escapes, control bytes, valid and broken UTF-8, truncation, stalls");
        if (err_count == 0)
            $display("json_string_escaper_utf8_top_tb: clean");
        else
            $display("json_string_escaper_utf8_top_tb: errors");
        $finish;
    end

endmodule

>>> sim.f
sv/jse_pkg.sv
sv/jse_front.sv
sv/jse_queue.sv
sv/jse_back.sv
sv/json_string_escaper_utf8_top.sv
dv/json_string_escaper_utf8_top_tb.sv
